[hw/rtl/tick_task_timer_bank_assert.svh]
// ----------------------------------------------------------------------------
// tick_task_timer_bank_assert.svh
// Assertion macros for the timer bank. Each macro needs clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_TIMER_BANK_ASSERT_SVH
`define TICK_TASK_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TTTB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define TTTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tttb_pkg.sv]
// ----------------------------------------------------------------------------
// tttb_pkg
// Types and command codes shared by the tick/task timer bank.
// ----------------------------------------------------------------------------
package tttb_pkg;

	// Command codes carried by func
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_ARM     = 2'd1;
	localparam logic [1:0] FUNC_COLLECT = 2'd2;

	// Fixed widths of the command word and result word fields
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned TAG_IN_W   = 8;
	localparam int unsigned IVAL_IN_W  = 16;
	localparam int unsigned SLOT_OUT_W = 3;
	localparam int unsigned PEND_OUT_W = 8;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_ARM,
		ST_RESULT
	} state_t;

endpackage

[hw/rtl/tick_task_timer_bank.sv]
// ----------------------------------------------------------------------------
// tick_task_timer_bank
// Bank of tagged countdown timers (periodic or one-shot) with a shared
// decrementer that visits one slot per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (func, handler_tag, interval, oneshot) is taken on a rising
//   edge with start high and busy low. Every command gives exactly one result
//   word (status, slot, pending), shown for one cycle with done high. The
//   receiver has no backpressure; done is never held.
//   Tick:    one slot per cycle through the shared decrement/compare unit,
//            every slot visited once, result in the following cycle.
//   Arm:     tag search walks the slots one per cycle and stops on a match;
//            else it ends at the last slot, result in the following cycle.
//   Collect and the unused code: result in the cycle after acceptance.
//   busy is low while the result is shown, so the next command can be taken
//   in that cycle. The walk over the slots sets how long a tick or an arm
//   lasts.
//   Reset (arst_n low) clears all slots, the pending mask and the sequencer;
//   no sweep is needed afterwards.
// ----------------------------------------------------------------------------
module tick_task_timer_bank #(
	parameter int unsigned SLOTS       = 8,
	parameter int unsigned COUNT_WIDTH = 16,
	parameter int unsigned TAG_WIDTH   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [tttb_pkg::FUNC_W-1:0]       func,
	input  logic [tttb_pkg::TAG_IN_W-1:0]     handler_tag,
	input  logic [tttb_pkg::IVAL_IN_W-1:0]    interval,
	input  logic                              oneshot,
	output logic                              done,
	output logic                              status,
	output logic [tttb_pkg::SLOT_OUT_W-1:0]   slot,
	output logic [tttb_pkg::PEND_OUT_W-1:0]   pending
);

	import tttb_pkg::*;

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	// Slot state
	logic [COUNT_WIDTH-1:0] ival_q  [SLOTS];
	logic [COUNT_WIDTH-1:0] count_q [SLOTS];
	logic [TAG_WIDTH-1:0]   tag_q   [SLOTS];
	logic [SLOTS-1:0]       os_q;
	logic [SLOTS-1:0]       used_q;
	logic [SLOTS-1:0]       pend_q;

	// Sequencer and latched command word
	state_t                 state_q, state_d;
	logic [IW-1:0]          idx_q;
	logic [TAG_WIDTH-1:0]   cmd_tag_q;
	logic [COUNT_WIDTH-1:0] cmd_ival_q;
	logic                   cmd_os_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_idx_q;

	// Result word registers
	logic                   res_status_q;
	logic [SLOT_OUT_W-1:0]  res_slot_q;
	logic [PEND_OUT_W-1:0]  res_pend_q;

	// Control decode
	logic accept, tick_step, arm_step, last_step;

	// Shared unit and arm search terms
	logic [COUNT_WIDTH-1:0] cur_ival, cur_count, cnt_dec;
	logic                   cur_active, cnt_le1;
	logic                   arm_hit, cur_free, arm_take, arm_fail;
	logic [IW-1:0]          arm_idx;

	// Next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE, ST_RESULT: begin
				if (start) begin
					case (func)
						FUNC_TICK: state_d = ST_TICK;
						FUNC_ARM:  state_d = ST_ARM;
						default:   state_d = ST_RESULT;
					endcase
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (last_step) state_d = ST_RESULT;
			end
			ST_ARM: begin
				if (arm_hit || last_step) state_d = ST_RESULT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode
	always_comb begin
		busy      = (state_q == ST_TICK) || (state_q == ST_ARM);
		done      = (state_q == ST_RESULT);
		accept    = start && !busy;
		tick_step = (state_q == ST_TICK);
		arm_step  = (state_q == ST_ARM);
		last_step = (idx_q == LAST_IDX);
	end

	// Shared decrement/compare unit on the visited slot
	always_comb begin
		cur_ival   = ival_q[idx_q];
		cur_count  = count_q[idx_q];
		cur_active = (cur_ival != '0);
		cnt_dec    = cur_count - COUNT_WIDTH'(1);
		cnt_le1    = ((cur_count >> 1) == '0);
	end

	// Arm search: a tag match wins, else the first inactive slot
	always_comb begin
		arm_hit  = used_q[idx_q] && (tag_q[idx_q] == cmd_tag_q);
		cur_free = !cur_active;
		arm_take = arm_hit || (last_step && (free_found_q || cur_free));
		arm_fail = last_step && !arm_hit && !free_found_q && !cur_free;
		arm_idx  = (!arm_hit && free_found_q) ? free_idx_q : idx_q;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Datapath: slot state, pending mask, walk index, result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ival_q[i]  <= '0;
				count_q[i] <= '0;
				tag_q[i]   <= '0;
			end
			os_q         <= '0;
			used_q       <= '0;
			pend_q       <= '0;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			cmd_tag_q    <= '0;
			cmd_ival_q   <= '0;
			cmd_os_q     <= 1'b0;
			res_status_q <= 1'b0;
			res_slot_q   <= '0;
			res_pend_q   <= '0;
		end else begin
			if (accept) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				cmd_tag_q    <= TAG_WIDTH'(handler_tag);
				cmd_ival_q   <= COUNT_WIDTH'(interval);
				cmd_os_q     <= oneshot;
				res_status_q <= 1'b0;
				res_slot_q   <= '0;
				// Collect returns the mask and clears it in the same step
				res_pend_q   <= (func == FUNC_COLLECT) ? PEND_OUT_W'(pend_q) : '0;
				if (func == FUNC_COLLECT) begin
					pend_q <= '0;
				end
			end

			// Tick: advance the visited slot
			if (tick_step) begin
				if (cur_active) begin
					if (cnt_le1) begin
						pend_q[idx_q] <= 1'b1;
						if (os_q[idx_q]) begin
							ival_q[idx_q]  <= '0;
							count_q[idx_q] <= '0;
						end else begin
							count_q[idx_q] <= cur_ival;
						end
					end else begin
						count_q[idx_q] <= cnt_dec;
					end
				end
				if (!last_step) idx_q <= idx_q + IW'(1);
			end

			// Arm: search, then program the chosen slot
			if (arm_step) begin
				if (arm_take) begin
					ival_q[arm_idx]  <= cmd_ival_q;
					count_q[arm_idx] <= cmd_ival_q;
					tag_q[arm_idx]   <= cmd_tag_q;
					os_q[arm_idx]    <= cmd_os_q;
					used_q[arm_idx]  <= 1'b1;
					res_slot_q       <= SLOT_OUT_W'(arm_idx);
				end else if (arm_fail) begin
					res_status_q <= 1'b1;
				end else begin
					if (cur_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					idx_q <= idx_q + IW'(1);
				end
			end
		end
	end

	assign status  = res_status_q;
	assign slot    = res_slot_q;
	assign pending = res_pend_q;

	// Checks
	`include "tick_task_timer_bank_assert.svh"

	`TTTB_ASSERT_IMPL(a_fail_word_clean, done && status, (slot == '0) && (pending == '0), "failed arm with nonzero slot or mask")
	`TTTB_ASSERT_NEXT(a_accept_progress, accept, busy || done, "accepted command made no progress")
	`TTTB_ASSERT_IMPL(a_walk_in_range, busy, idx_q <= LAST_IDX, "slot walk index out of range")

endmodule
